/* rtl/tfis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tfis_pkg;
  localparam int unsigned Depth = 1024;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW = AddrW + 1;
  localparam int unsigned SlotW = 10;
  localparam logic [63:0] TargetLimit = 64'h8000000000000000;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_STORE = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_SEEK  = 3'd3,
    MODE_STEP  = 3'd4,
    MODE_NEXT  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_WRONG    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE_RD,
    S_BASE_WT,
    S_BS_CHECK,
    S_BS_WT,
    S_FIN_RD,
    S_FIN_WT,
    S_SORT_RD_I,
    S_SORT_WT_I,
    S_SORT_RD_J,
    S_SORT_WT_J,
    S_OUT
  } state_e;
endpackage
`default_nettype wire

/* rtl/timestamped_frame_index_seek_core.sv */
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid_i/in_stall_o  | mode_i, timestamp_i, offset_us_i
// out     | output    | out_valid_o/out_stall_i | status_o, frame_slot_o, found_time_o
//
// Start, store and requests refused at once are registered into the result on acceptance;
// next and step past the end pass through FIN_RD and FIN_WT, a seek target overflow through
// BASE_WT and BS_CHECK. Seek and step run a binary search over one entry memory, with at
// most floor(log2(entries))+1 halvings, each a read of mid and a compare.
// Stop runs a stable insertion sort in the same memory: each entry is read, then each
// larger entry below it is read and written one place up before the entry is written back.
// Reset clears count, cursor and recording; the entry memory is undefined until written.
// One request at a time; the next request waits until the result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module timestamped_frame_index_seek_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [2:0]                    mode_i,
  input  wire logic [63:0]                   timestamp_i,
  input  wire logic signed [63:0]            offset_us_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         status_o,
  output logic [tfis_pkg::SlotW-1:0]         frame_slot_o,
  output logic [63:0]                        found_time_o
);
  import tfis_pkg::*;

  // entry memory: timestamp and slot per word
  logic [63+SlotW:0] mem_q [Depth];
  logic [63+SlotW:0] rd_q;
  logic              we;
  logic [AddrW-1:0]  wa, ra;
  logic [63+SlotW:0] wd;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, cur_q, cur_d;
  logic rec_q, rec_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  logic [63:0] tgt_q, tgt_d, off10_q, off10_d;
  logic [63+SlotW:0] key_q, key_d;
  logic [2:0] st_q, st_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [63:0] time_q, time_d;
  logic [CntW-1:0] mid;
  logic [63:0] off64;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign off64 = offset_us_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      cur_q <= '0;
      rec_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      cur_q <= cur_d;
      rec_q <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    i_q <= i_d;
    j_q <= j_d;
    tgt_q <= tgt_d;
    off10_q <= off10_d;
    key_q <= key_d;
    st_q <= st_d;
    slot_q <= slot_d;
    time_q <= time_d;
  end

  // sequence each request through the memory
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cur_d = cur_q;
    rec_d = rec_q;
    lo_d = lo_q;
    hi_d = hi_q;
    i_d = i_q;
    j_d = j_q;
    tgt_d = tgt_q;
    off10_d = off10_q;
    key_d = key_q;
    st_d = st_q;
    slot_d = slot_q;
    time_d = time_q;
    we = 1'b0;
    wa = '0;
    wd = '0;
    ra = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d = ST_OK;
          slot_d = '0;
          time_d = '0;
          off10_d = (off64 << 3) + (off64 << 1);
          state_d = S_OUT;
          case (mode_i)
            MODE_START: begin
              if (rec_q) st_d = ST_BUSY;
              else begin
                rec_d = 1'b1;
                cnt_d = '0;
                cur_d = '0;
              end
            end
            MODE_STORE: begin
              if (cnt_q >= CntW'(Depth)) st_d = ST_FULL;
              else begin
                we = 1'b1;
                wa = cnt_q[AddrW-1:0];
                wd = {timestamp_i, SlotW'(cnt_q)};
                slot_d = SlotW'(cnt_q);
                time_d = timestamp_i;
                cnt_d = cnt_q + 1'b1;
              end
            end
            MODE_STOP: begin
              if (!rec_q) st_d = ST_WRONG;
              else begin
                rec_d = 1'b0;
                cur_d = '0;
                i_d = CntW'(1);
                state_d = S_SORT_RD_I;
              end
            end
            MODE_SEEK, MODE_STEP, MODE_NEXT: begin
              if (rec_q) st_d = ST_BUSY;
              else if (cnt_q == '0) st_d = ST_EMPTY;
              else if (mode_i == MODE_SEEK) begin
                ra = '0;
                state_d = S_BASE_WT;
              end else if (cur_q >= cnt_q) begin
                if (mode_i == MODE_NEXT) st_d = ST_WRONG;
                else begin
                  cur_d = cnt_q;
                  lo_d = cnt_q - 1'b1;
                  state_d = S_FIN_RD;
                end
              end else if (mode_i == MODE_NEXT) begin
                lo_d = cur_q;
                cur_d = cur_q + 1'b1;
                state_d = S_FIN_RD;
              end else begin
                ra = cur_q[AddrW-1:0];
                state_d = S_BASE_WT;
              end
            end
            default: st_d = ST_WRONG;
          endcase
        end
      end
      S_BASE_WT: begin
        tgt_d = rd_q[63+SlotW:SlotW] + off10_q;
        state_d = S_BS_CHECK;
      end
      S_BS_CHECK: begin
        if (tgt_q > TargetLimit) begin
          st_d = ST_OVERFLOW;
          state_d = S_OUT;
        end else begin
          lo_d = '0;
          hi_d = cnt_q;
          state_d = S_BASE_RD;
        end
      end
      // binary search: issue read of mid
      S_BASE_RD: begin
        if (lo_q < hi_q) begin
          ra = mid[AddrW-1:0];
          state_d = S_BS_WT;
        end else begin
          if (lo_q >= cnt_q) lo_d = cnt_q - 1'b1;
          cur_d = (lo_q >= cnt_q) ? cnt_q - 1'b1 : lo_q;
          state_d = S_FIN_RD;
        end
      end
      S_BS_WT: begin
        if (rd_q[63+SlotW:SlotW] < tgt_q) lo_d = mid + 1'b1;
        else hi_d = mid;
        state_d = S_BASE_RD;
      end
      S_FIN_RD: begin
        ra = lo_q[AddrW-1:0];
        state_d = S_FIN_WT;
      end
      S_FIN_WT: begin
        slot_d = rd_q[SlotW-1:0];
        time_d = rd_q[63+SlotW:SlotW];
        state_d = S_OUT;
      end
      // insertion sort: pick up entry i, shift larger ones up
      S_SORT_RD_I: begin
        if (i_q < cnt_q) begin
          ra = i_q[AddrW-1:0];
          state_d = S_SORT_WT_I;
        end else state_d = S_OUT;
      end
      S_SORT_WT_I: begin
        key_d = rd_q;
        j_d = i_q;
        state_d = S_SORT_RD_J;
      end
      S_SORT_RD_J: begin
        if (j_q == '0) begin
          we = 1'b1;
          wa = '0;
          wd = key_q;
          i_d = i_q + 1'b1;
          state_d = S_SORT_RD_I;
        end else begin
          ra = AddrW'(j_q - 1'b1);
          state_d = S_SORT_WT_J;
        end
      end
      S_SORT_WT_J: begin
        we = 1'b1;
        wa = j_q[AddrW-1:0];
        if (rd_q[63+SlotW:SlotW] > key_q[63+SlotW:SlotW]) begin
          wd = rd_q;
          j_d = j_q - 1'b1;
          state_d = S_SORT_RD_J;
        end else begin
          wd = key_q;
          i_d = i_q + 1'b1;
          state_d = S_SORT_RD_I;
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == S_OUT);
  assign status_o = st_q;
  assign frame_slot_o = slot_q;
  assign found_time_o = time_q;
endmodule
`default_nettype wire
